>>> hdl/sparse_table_range_max_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sparse table range maximum engine
// Concurrent checks clocked on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SPARSE_TABLE_RANGE_MAX_TOP_ASSERT_SVH
`define SPARSE_TABLE_RANGE_MAX_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define STRM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("strm assertion failed");
`define STRM_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) \
    else $error("strm forbidden condition");
`else
`define STRM_ASSERT(lbl, prop)
`define STRM_NEVER(lbl, expr)
`endif

`endif

>>> hdl/strm_pkg.sv
// ----------------------------------------------------------------------------
// strm_pkg
// Shared types, codes and helpers of the sparse table range maximum engine.
// ----------------------------------------------------------------------------
package strm_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BUILD = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD_A,
    S_RD_B,
    S_RD_VA,
    S_RD_VB,
    S_CMP,
    S_PUT
  } state_e;

  typedef struct packed {
    logic build_mode;
    logic load;
    logic build_init;
    logic q_capture;
    logic am_rd_a;
    logic am_rd_b;
    logic el_rd_a;
    logic el_rd_b;
    logic cap_ia;
    logic cap_ib;
    logic cap_va;
    logic build_step;
    logic cmp_result;
    logic set_built;
    logic push_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic few;
    logic build_done;
    logic q_ok;
    logic out_free;
  } dp_status_t;

  function automatic logic [5:0] flog2(input logic [31:0] x);
    logic [5:0] r;
    r = '0;
    for (int b = 1; b < 32; b++) begin
      if (x[b]) r = 6'(b);
    end
    return r;
  endfunction

endpackage

>>> hdl/sparse_table_range_max_top.sv
// ----------------------------------------------------------------------------
// sparse_table_range_max_top
// Range maximum engine: element store plus sparse table of argmax indices.
// ----------------------------------------------------------------------------
// A load is taken without leaving the idle state, and so is a build when the
// set is too small to need a table (fewer than two elements). A build over n
// elements sweeps every table level from one up, n - 2^k + 1 entries at
// level k, each written by passing through S_RD_A, S_RD_B, S_RD_VA, S_RD_VB
// and S_CMP. A range query runs through the same states into S_PUT, an
// invalid query straight to S_PUT; these steps follow from the single read
// port of the argmax store and of the element store, each read once per
// window. Only a query yields a result beat; a waiting result does not block loads or builds.
module sparse_table_range_max_top #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int VALUE_BITS   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [31:0] value_i,
  input  logic [9:0]  range_first_i,
  input  logic [9:0]  range_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] max_value_o,
  output logic [9:0]  max_index_o,
  output logic        range_ok_o
);

  import strm_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;

  strm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .command_i  (command_i),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  strm_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .VALUE_BITS   (VALUE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .st_o          (st),
    .value_i       (value_i),
    .range_first_i (range_first_i),
    .range_last_i  (range_last_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .max_value_o   (max_value_o),
    .max_index_o   (max_index_o),
    .range_ok_o    (range_ok_o)
  );

endmodule

>>> hdl/strm_ram.sv
// ----------------------------------------------------------------------------
// strm_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module strm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    if (re_i) rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/strm_ctrl.sv
// ----------------------------------------------------------------------------
// strm_ctrl
// Sequencer for loads, the table build sweep and range queries.
// ----------------------------------------------------------------------------
module strm_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            command_i,
  input  strm_pkg::dp_status_t  st_i,
  output strm_pkg::ctrl_cmd_t   cmd_o
);

  import strm_pkg::*;

  `include "sparse_table_range_max_top_assert.svh"

  state_e state_q, state_d;
  logic   mode_q, mode_d;
  logic   acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign acc        = in_valid_i & in_ready_o;

  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    cmd_o   = '0;
    cmd_o.build_mode = mode_q;
    unique case (state_q)
      S_IDLE: begin
        if (acc) begin
          unique case (command_i)
            CMD_LOAD: cmd_o.load = 1'b1;
            CMD_BUILD: begin
              if (st_i.few) begin
                cmd_o.set_built = 1'b1;
              end else begin
                cmd_o.build_init = 1'b1;
                mode_d  = 1'b1;
                state_d = S_RD_A;
              end
            end
            CMD_QUERY: begin
              cmd_o.q_capture = 1'b1;
              mode_d  = 1'b0;
              state_d = st_i.q_ok ? S_RD_A : S_PUT;
            end
            default: ;
          endcase
        end
      end
      S_RD_A: begin
        cmd_o.am_rd_a = 1'b1;
        state_d = S_RD_B;
      end
      S_RD_B: begin
        cmd_o.am_rd_b = 1'b1;
        cmd_o.cap_ia  = 1'b1;
        state_d = S_RD_VA;
      end
      S_RD_VA: begin
        cmd_o.cap_ib  = 1'b1;
        cmd_o.el_rd_a = 1'b1;
        state_d = S_RD_VB;
      end
      S_RD_VB: begin
        cmd_o.el_rd_b = 1'b1;
        cmd_o.cap_va  = 1'b1;
        state_d = S_CMP;
      end
      S_CMP: begin
        if (mode_q) begin
          cmd_o.build_step = 1'b1;
          if (st_i.build_done) begin
            cmd_o.set_built = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_RD_A;
          end
        end else begin
          cmd_o.cmp_result = 1'b1;
          state_d = S_PUT;
        end
      end
      S_PUT: begin
        if (st_i.out_free) begin
          cmd_o.push_out = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  `STRM_ASSERT(a_query_leaves_idle,
    (acc && command_i == CMD_QUERY) |=> state_q != S_IDLE)
  `STRM_ASSERT(a_put_only_for_query, (state_q == S_PUT) |-> !mode_q)
  `STRM_NEVER(a_busy_no_accept, acc && state_q != S_IDLE)

endmodule

>>> hdl/strm_dp.sv
// ----------------------------------------------------------------------------
// strm_dp
// Element store, argmax level store, index arithmetic and result registers.
// ----------------------------------------------------------------------------
module strm_dp #(
  parameter int MAX_ELEMENTS = 1024,
  parameter int VALUE_BITS   = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  strm_pkg::ctrl_cmd_t  cmd_i,
  output strm_pkg::dp_status_t st_o,
  input  logic [31:0]          value_i,
  input  logic [9:0]           range_first_i,
  input  logic [9:0]           range_last_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [31:0]          max_value_o,
  output logic [9:0]           max_index_o,
  output logic                 range_ok_o
);

  import strm_pkg::*;

  `include "sparse_table_range_max_top_assert.svh"

  localparam int IDX_W    = $clog2(MAX_ELEMENTS);
  localparam int CNT_W    = $clog2(MAX_ELEMENTS + 1);
  localparam int CMP_W    = (CNT_W > 10) ? CNT_W : 11;
  localparam int LVL_W    = $clog2(IDX_W + 1);
  localparam int SP_W     = CNT_W + 2;
  localparam int AM_AW    = LVL_W + IDX_W;
  localparam int AM_DEPTH = 1 << AM_AW;

  logic [CNT_W-1:0]      count_q, count_d, base;
  logic                  built_q, built_d;
  logic [LVL_W-1:0]      k_q, k_d;
  logic [IDX_W-1:0]      i_q, i_d;
  logic [IDX_W-1:0]      last_q;
  logic [IDX_W-1:0]      ia_q, ib_q;
  logic [VALUE_BITS-1:0] va_q;
  logic [31:0]           res_value_q;
  logic [IDX_W-1:0]      res_index_q;
  logic                  res_ok_q;
  logic                  out_valid_q;
  logic [31:0]           out_value_q;
  logic [9:0]            out_index_q;
  logic                  out_ok_q;

  logic [CMP_W-1:0]      first_e, last_e, cnt_e;
  logic [10:0]           len;
  logic [LVL_W-1:0]      q_k, km1;
  logic [IDX_W-1:0]      half, qspan, a_idx, b_idx;
  logic [SP_W-1:0]       span, span2, reach;
  logic                  level_end;

  logic                  am_we;
  logic [AM_AW-1:0]      am_waddr, am_raddr;
  logic [IDX_W-1:0]      am_wdata, am_rdata;
  logic                  el_we, el_re, am_re;
  logic [IDX_W-1:0]      el_raddr;
  logic [VALUE_BITS-1:0] el_rdata;
  logic                  a_wins;
  logic [IDX_W-1:0]      pick;

  assign base    = built_q ? '0 : count_q;
  assign first_e = CMP_W'(range_first_i);
  assign last_e  = CMP_W'(range_last_i);
  assign cnt_e   = CMP_W'(count_q);
  assign len     = 11'(range_last_i) - 11'(range_first_i) + 11'd1;
  assign q_k     = LVL_W'(flog2(32'(len)));

  assign st_o.few      = (count_q < CNT_W'(2));
  assign st_o.q_ok     = built_q && (first_e < cnt_e) && (last_e < cnt_e) &&
                         !(range_last_i < range_first_i);
  assign st_o.out_free = !out_valid_q || out_ready_i;

  assign km1       = k_q - LVL_W'(1);
  assign half      = IDX_W'(1) << km1;
  assign qspan     = IDX_W'(1) << k_q;
  assign span      = SP_W'(1) << k_q;
  assign span2     = span << 1;
  assign reach     = SP_W'(i_q) + span;
  assign level_end = (reach == SP_W'(count_q));
  assign st_o.build_done = level_end && (span2 > SP_W'(count_q));

  assign a_idx = i_q;
  assign b_idx = cmd_i.build_mode ? (i_q + half) : (last_q + IDX_W'(1) - qspan);

  always_comb begin
    am_raddr = cmd_i.build_mode ? {km1, a_idx} : {k_q, a_idx};
    if (cmd_i.am_rd_b) begin
      am_raddr = cmd_i.build_mode ? {km1, b_idx} : {k_q, b_idx};
    end
  end
  assign am_re = cmd_i.am_rd_a | cmd_i.am_rd_b;

  assign el_we    = cmd_i.load && (base < CNT_W'(MAX_ELEMENTS));
  assign el_re    = cmd_i.el_rd_a | cmd_i.el_rd_b;
  assign el_raddr = cmd_i.el_rd_b ? ib_q : ia_q;

  assign a_wins = (va_q > el_rdata);
  assign pick   = a_wins ? ia_q : ib_q;

  always_comb begin
    am_we    = el_we;
    am_waddr = {LVL_W'(0), IDX_W'(base)};
    am_wdata = IDX_W'(base);
    if (cmd_i.build_step) begin
      am_we    = 1'b1;
      am_waddr = {k_q, i_q};
      am_wdata = pick;
    end
  end

  strm_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ELEMENTS)) u_elem_ram (
    .clk_i   (clk_i),
    .we_i    (el_we),
    .waddr_i (IDX_W'(base)),
    .wdata_i (VALUE_BITS'(value_i)),
    .re_i    (el_re),
    .raddr_i (el_raddr),
    .rdata_o (el_rdata)
  );

  strm_ram #(.WIDTH(IDX_W), .DEPTH(AM_DEPTH)) u_argmax_ram (
    .clk_i   (clk_i),
    .we_i    (am_we),
    .waddr_i (am_waddr),
    .wdata_i (am_wdata),
    .re_i    (am_re),
    .raddr_i (am_raddr),
    .rdata_o (am_rdata)
  );

  always_comb begin
    count_d = count_q;
    built_d = built_q;
    k_d     = k_q;
    i_d     = i_q;
    if (cmd_i.load) begin
      built_d = 1'b0;
      count_d = el_we ? base + CNT_W'(1) : base;
    end
    if (cmd_i.set_built) built_d = 1'b1;
    if (cmd_i.build_init) begin
      k_d = LVL_W'(1);
      i_d = '0;
    end
    if (cmd_i.q_capture) begin
      k_d = q_k;
      i_d = IDX_W'(range_first_i);
    end
    if (cmd_i.build_step) begin
      if (level_end) begin
        k_d = k_q + LVL_W'(1);
        i_d = '0;
      end else begin
        i_d = i_q + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      built_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      built_q <= built_d;
      if (cmd_i.push_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    k_q <= k_d;
    i_q <= i_d;
    if (cmd_i.q_capture) begin
      last_q      <= IDX_W'(range_last_i);
      res_value_q <= 32'({VALUE_BITS{1'b1}});
      res_index_q <= '0;
      res_ok_q    <= 1'b0;
    end
    if (cmd_i.cap_ia) ia_q <= am_rdata;
    if (cmd_i.cap_ib) ib_q <= am_rdata;
    if (cmd_i.cap_va) va_q <= el_rdata;
    if (cmd_i.cmp_result) begin
      res_value_q <= 32'(a_wins ? va_q : el_rdata);
      res_index_q <= pick;
      res_ok_q    <= 1'b1;
    end
    if (cmd_i.push_out) begin
      out_value_q <= res_value_q;
      out_index_q <= 10'(res_index_q);
      out_ok_q    <= res_ok_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign max_value_o = out_value_q;
  assign max_index_o = out_index_q;
  assign range_ok_o  = out_ok_q;

  `STRM_NEVER(a_count_bound, count_q > CNT_W'(MAX_ELEMENTS))
  `STRM_ASSERT(a_invalid_index_zero, (out_valid_q && !out_ok_q) |-> out_index_q == '0)
  `STRM_ASSERT(a_build_sets_flag,
    (cmd_i.build_step && st_o.build_done) |=> built_q)

endmodule
